### rtl/stp_pkg.sv
// Shared types, register indexes and coil tables for the half-step stepper driver.
package stp_pkg;

    typedef enum logic [2:0] {
        CFG_SPEED_PERIOD     = 3'd0,
        CFG_SWING_MODE       = 3'd1,
        CFG_SWING_LOW_ANGLE  = 3'd2,
        CFG_SWING_HIGH_ANGLE = 3'd3,
        CFG_LOW_OVERSHOOT    = 3'd4,
        CFG_HIGH_OVERSHOOT   = 3'd5
    } cfg_index_t;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef struct packed {
        logic [7:0]         speed_period;
        logic               swing_mode;
        logic signed [15:0] swing_low_angle;
        logic signed [15:0] swing_high_angle;
        logic [14:0]        low_overshoot;
        logic [14:0]        high_overshoot;
    } cfg_t;

    typedef struct packed {
        logic               turn_clockwise;
        logic               swing_update;
        logic signed [15:0] target_angle;
        logic               load_position;
        logic signed [15:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         coil_pattern;
        logic signed [15:0] position;
        logic               moving;
    } out_item_t;

    // Half-step coil patterns, bit 3 is coil A and bit 0 is coil D.
    localparam logic [3:0] CW_TABLE [8] = '{
        4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
    };
    localparam logic [3:0] CCW_TABLE [8] = '{
        4'h8, 4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC
    };

    function automatic logic [3:0] coil_lookup(input logic cw, input logic [2:0] phase);
        coil_lookup = cw ? CW_TABLE[phase] : CCW_TABLE[phase];
    endfunction

endpackage

### rtl/stp_cfg_regs.sv
// Configuration register file written through the plain write port.
module stp_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [stp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [stp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output stp_pkg::cfg_t                        cfg
);
    import stp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SPEED_PERIOD:     cfg_reg.speed_period     <= cfg_data[7:0];
                CFG_SWING_MODE:       cfg_reg.swing_mode       <= cfg_data[0];
                CFG_SWING_LOW_ANGLE:  cfg_reg.swing_low_angle  <= signed'(cfg_data);
                CFG_SWING_HIGH_ANGLE: cfg_reg.swing_high_angle <= signed'(cfg_data);
                CFG_LOW_OVERSHOOT:    cfg_reg.low_overshoot    <= cfg_data[14:0];
                CFG_HIGH_OVERSHOOT:   cfg_reg.high_overshoot   <= cfg_data[14:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/stp_core.sv
// Per-tick step logic: position load, swing target update, settle delay and stepping.
module stp_core #(
    parameter int SETTLE_TICKS   = 100,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  stp_pkg::in_item_t   item,
    input  stp_pkg::cfg_t       cfg,
    output stp_pkg::out_item_t  result
);
    import stp_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int EW = ((PW > 17) ? PW : 17) + 1;
    localparam logic signed [EW-1:0] POS_MAX = EW'((64'sd1 <<< (PW - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] POS_MIN = -POS_MAX - EW'(1);
    localparam logic [6:0] SETTLE_LOAD = 7'(SETTLE_TICKS);

    logic [2:0]          phase_reg,     phase_next;
    logic [7:0]          countdown_reg, countdown_next;
    logic [6:0]          settle_reg,    settle_next;
    logic signed [PW-1:0] cur_reg,      cur_next;
    logic signed [PW-1:0] tgt_reg,      tgt_next;
    logic                toward_high_reg, toward_high_next;
    logic [3:0]          coil_reg,      coil_next;

    logic signed [PW-1:0] cur_loaded;
    logic signed [PW-1:0] cur_swung;
    logic signed [PW-1:0] low_end;
    logic signed [PW-1:0] high_end;
    logic signed [PW-1:0] low_turn;
    logic signed [PW-1:0] high_turn;
    logic signed [EW-1:0] cur_ext;

    function automatic logic signed [EW-1:0] sext16(input logic signed [15:0] v);
        sext16 = {{(EW-16){v[15]}}, v};
    endfunction

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] clamped;
        clamped = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
        sat_pos = clamped[PW-1:0];
    endfunction

    always_comb
    begin
        low_end   = sat_pos(sext16(cfg.swing_low_angle));
        high_end  = sat_pos(sext16(cfg.swing_high_angle));
        low_turn  = sat_pos(sext16(cfg.swing_low_angle)
                            - {{(EW-15){1'b0}}, cfg.low_overshoot});
        high_turn = sat_pos(sext16(cfg.swing_high_angle)
                            + {{(EW-15){1'b0}}, cfg.high_overshoot});

        cur_loaded = item.load_position ? sat_pos(sext16(item.load_value)) : cur_reg;

        cur_swung        = cur_loaded;
        tgt_next         = tgt_reg;
        toward_high_next = toward_high_reg;
        if (!cfg.swing_mode)
        begin
            tgt_next = sat_pos(sext16(item.target_angle));
        end
        else if (item.swing_update)
        begin
            if (!toward_high_reg)
            begin
                tgt_next = low_turn;
                if (cur_loaded <= low_turn)
                begin
                    toward_high_next = 1'b1;
                    cur_swung        = low_end;
                end
            end
            else
            begin
                tgt_next = high_turn;
                if (cur_loaded >= high_turn)
                begin
                    toward_high_next = 1'b0;
                    cur_swung        = high_end;
                end
            end
        end

        cur_next       = cur_swung;
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        settle_next    = settle_reg;
        coil_next      = coil_reg;
        if (cur_swung == tgt_next || cfg.speed_period == 8'd0)
        begin
            coil_next = 4'h0;
            if (settle_reg == 7'd0)
            begin
                settle_next = SETTLE_LOAD;
            end
        end
        else if (settle_reg != 7'd0)
        begin
            settle_next = settle_reg - 7'd1;
        end
        else if (countdown_reg > 8'd1)
        begin
            countdown_next = countdown_reg - 8'd1;
        end
        else
        begin
            countdown_next = cfg.speed_period;
            coil_next      = coil_lookup(item.turn_clockwise, phase_reg);
            // The target lies strictly beyond the position, so neither move can overflow.
            if (cur_swung < tgt_next)
            begin
                cur_next   = cur_swung + PW'(1);
                phase_next = phase_reg + 3'd1;
            end
            else
            begin
                cur_next   = cur_swung - PW'(1);
                phase_next = phase_reg - 3'd1;
            end
        end

        cur_ext             = {{(EW-PW){cur_next[PW-1]}}, cur_next};
        result.coil_pattern = coil_next;
        result.position     = cur_ext[15:0];
        result.moving       = (cur_next != tgt_next) && (cfg.speed_period != 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            countdown_reg   <= '0;
            settle_reg      <= '0;
            cur_reg         <= '0;
            tgt_reg         <= '0;
            toward_high_reg <= 1'b0;
            coil_reg        <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            countdown_reg   <= countdown_next;
            settle_reg      <= settle_next;
            cur_reg         <= cur_next;
            tgt_reg         <= tgt_next;
            toward_high_reg <= toward_high_next;
            coil_reg        <= coil_next;
        end
    end

endmodule

### rtl/stepper_halfstep_position_driver.sv
// Top level of the half-step stepper position driver with input and result registers.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid / in_stall   turn_clockwise, swing_update, target_angle,
//                                             load_position, load_value
//   out      source     out_valid / out_stall coil_pattern, position, moving
//   cfg      sink       cfg_write             cfg_index, cfg_data
//
// An accepted beat lands in the input register and is processed in the following cycle
// unless the result side stalls; its result is then written to the result register.
// One beat is accepted every cycle while the result side keeps up; the step logic
// computes each next state combinationally from its own state registers.
// Reset clears the control state and all configuration registers.
// A stall on the result side holds the result register and then the input register.
module stepper_halfstep_position_driver #(
    parameter int SETTLE_TICKS   = 100,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                turn_clockwise,
    input  logic                                swing_update,
    input  logic signed [15:0]                  target_angle,
    input  logic                                load_position,
    input  logic signed [15:0]                  load_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [3:0]                          coil_pattern,
    output logic signed [15:0]                  position,
    output logic                                moving,
    input  logic                                cfg_write,
    input  logic [stp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [stp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import stp_pkg::*;

    cfg_t      cfg;
    in_item_t  item_reg;
    out_item_t result;
    out_item_t result_reg;
    logic      item_valid_reg;
    logic      out_valid_reg;
    logic      out_free;
    logic      item_fire;
    logic      in_fire;

    assign out_free  = !out_valid_reg || !out_stall;
    assign item_fire = item_valid_reg && out_free;
    assign in_stall  = item_valid_reg && !out_free;
    assign in_fire   = in_valid && !in_stall;

    stp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stp_core #(
        .SETTLE_TICKS   (SETTLE_TICKS),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (item_fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= in_fire || (item_valid_reg && !item_fire);
            if (item_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.turn_clockwise <= turn_clockwise;
            item_reg.swing_update   <= swing_update;
            item_reg.target_angle   <= target_angle;
            item_reg.load_position  <= load_position;
            item_reg.load_value     <= load_value;
        end
        if (item_fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coil_pattern = result_reg.coil_pattern;
    assign position     = result_reg.position;
    assign moving       = result_reg.moving;

endmodule

### tb/sv/tb_stepper_halfstep_position_driver.sv
// Testbench for the half-step stepper position driver: random and directed ticks against a predictor.
`timescale 1ns / 1ps

module tb_stepper_halfstep_position_driver;

    import stp_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_TICKS = 100;

    class halfstep_scoreboard;
        int errors;
        out_item_t pending_outputs[$];

        bit [7:0] speed;
        bit swing;
        int low_end;
        int high_end;
        int low_ov;
        int high_ov;

        bit [2:0] phase;
        bit [7:0] countdown;
        int settle;
        int cur;
        int tgt;
        bit toward_high;
        bit [3:0] coils;

        bit [3:0] cw_seq [8];
        bit [3:0] ccw_seq [8];

        function new();
            cw_seq = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};
            ccw_seq = '{4'h8, 4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC};
            errors = 0;
            speed = 0;
            swing = 0;
            low_end = 0;
            high_end = 0;
            low_ov = 0;
            high_ov = 0;
            phase = 0;
            countdown = 0;
            settle = 0;
            cur = 0;
            tgt = 0;
            toward_high = 0;
            coils = 0;
        endfunction

        static function int sat(int v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] val);
            case (idx)
                CFG_SPEED_PERIOD:     speed = val[7:0];
                CFG_SWING_MODE:       swing = val[0];
                CFG_SWING_LOW_ANGLE:  low_end = int'($signed(val));
                CFG_SWING_HIGH_ANGLE: high_end = int'($signed(val));
                CFG_LOW_OVERSHOOT:    low_ov = int'(val[14:0]);
                CFG_HIGH_OVERSHOOT:   high_ov = int'(val[14:0]);
                default:              ;
            endcase
        endfunction

        function void note_drive_tick(in_item_t t);
            out_item_t want;
            if (t.load_position)
                cur = sat(int'(t.load_value));
            if (!swing) begin
                tgt = int'(t.target_angle);
            end
            else if (t.swing_update) begin
                if (!toward_high) begin
                    tgt = sat(low_end - low_ov);
                    if (cur <= tgt) begin
                        toward_high = 1'b1;
                        cur = low_end;
                    end
                end
                else begin
                    tgt = sat(high_end + high_ov);
                    if (cur >= tgt) begin
                        toward_high = 1'b0;
                        cur = high_end;
                    end
                end
            end
            if (cur == tgt || speed == 0) begin
                coils = 4'h0;
                if (settle == 0)
                    settle = SETTLE_TICKS;
            end
            else if (settle > 0) begin
                settle--;
            end
            else if (countdown > 1) begin
                countdown--;
            end
            else begin
                countdown = speed;
                coils = t.turn_clockwise ? cw_seq[phase] : ccw_seq[phase];
                if (cur < tgt) begin
                    cur = sat(cur + 1);
                    phase = phase + 3'd1;
                end
                else begin
                    cur = sat(cur - 1);
                    phase = phase - 3'd1;
                end
            end
            want.coil_pattern = coils;
            want.position = cur[15:0];
            want.moving = (cur != tgt) && (speed != 0);
            pending_outputs.push_back(want);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_tick(out_item_t got);
            out_item_t want;
            if (pending_outputs.size() == 0) begin
                report($sformatf("result beat with nothing expected, position %0d",
                    $signed(got.position)));
                return;
            end
            want = pending_outputs.pop_front();
            if (got.coil_pattern !== want.coil_pattern)
                report($sformatf("coil_pattern %h, expected %h", got.coil_pattern,
                    want.coil_pattern));
            if (got.position !== want.position)
                report($sformatf("position %0d, expected %0d", $signed(got.position),
                    $signed(want.position)));
            if (got.moving !== want.moving)
                report($sformatf("moving %b, expected %b", got.moving, want.moving));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic turn_clockwise = 1'b0;
    logic swing_update = 1'b0;
    logic signed [15:0] target_angle = '0;
    logic load_position = 1'b0;
    logic signed [15:0] load_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] coil_pattern;
    logic signed [15:0] position;
    logic moving;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    halfstep_scoreboard sb = new();

    stepper_halfstep_position_driver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .turn_clockwise (turn_clockwise),
        .swing_update   (swing_update),
        .target_angle   (target_angle),
        .load_position  (load_position),
        .load_value     (load_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .coil_pattern   (coil_pattern),
        .position       (position),
        .moving         (moving),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        in_item_t seen;
        out_item_t got;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                seen = '{turn_clockwise, swing_update, target_angle, load_position, load_value};
                sb.note_drive_tick(seen);
            end
            if (out_valid && !out_stall) begin
                got = '{coil_pattern, position, moving};
                sb.check_tick(got);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end
            else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    task write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task set_config(int speed, int mode, int lo, int hi, int lov, int hov);
        write_reg(CFG_SPEED_PERIOD, speed[15:0]);
        write_reg(CFG_SWING_MODE, mode[15:0]);
        write_reg(CFG_SWING_LOW_ANGLE, lo[15:0]);
        write_reg(CFG_SWING_HIGH_ANGLE, hi[15:0]);
        write_reg(CFG_LOW_OVERSHOOT, lov[15:0]);
        write_reg(CFG_HIGH_OVERSHOOT, hov[15:0]);
        cfg_write <= 1'b0;
    endtask

    task set_idling(int mode);
        case (mode % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 48; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 48; end
            default: begin idle_pct = 32; stall_pct = 32; end
        endcase
    endtask

    // The sender holds off until every result has come back.
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task send_tick(logic cw, logic upd, logic signed [15:0] tgt, logic ld,
                   logic signed [15:0] ldv);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        turn_clockwise <= cw;
        swing_update <= upd;
        target_angle <= tgt;
        load_position <= ld;
        load_value <= ldv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task send_noise();
        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom()),
            1'($urandom_range(1)), 16'($urandom()));
    endtask

    function int pick_anchor();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32767 - $urandom_range(8);
        if (r == 1)
            return -32768 + $urandom_range(8);
        return $urandom_range(80) - 40;
    endfunction

    // Fixed mode: hold a target near an anchor, loaded at the start of most runs, for runs of random length.
    task run_fixed(int n_items, int max_len);
        int left;
        int len;
        int anchor;
        int goal;
        int k;
        bit cw;
        bit do_load;
        left = n_items;
        while (left > 0) begin
            anchor = pick_anchor();
            goal = halfstep_scoreboard::sat(anchor + $urandom_range(24) - 12);
            len = $urandom_range(max_len, 20);
            cw = 1'($urandom_range(1));
            do_load = ($urandom_range(99) < 70);
            for (k = 0; k < len && left > 0; k++) begin
                if ($urandom_range(99) < 7) begin
                    send_noise();
                end
                else begin
                    if ($urandom_range(99) < 10)
                        cw = ~cw;
                    send_tick(cw, 1'($urandom_range(1)), goal[15:0], do_load && k == 0,
                        anchor[15:0]);
                end
                left--;
            end
        end
    endtask

    task run_swing(int n_items, int lo_load, int hi_load);
        int k;
        int ldv;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 5) begin
                send_noise();
            end
            else begin
                ldv = $urandom_range(1) ? lo_load : hi_load;
                ldv = halfstep_scoreboard::sat(ldv + $urandom_range(8) - 4);
                send_tick(1'($urandom_range(1)), $urandom_range(99) < 20, 16'($urandom()),
                    $urandom_range(99) < 3, ldv[15:0]);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(1, 0, 0, 0, 0, 0);
        send_tick(1, 0, 2, 1, 0);
        send_tick(1, 0, 2, 0, 0);
        send_tick(1, 0, 2, 0, 0);
        send_tick(0, 1, 32767, 1, 32767);
        send_tick(0, 0, -32768, 1, -32768);
        send_tick(1, 0, 32767, 0, -1);
        send_tick(0, 0, -3, 1, -1);
        drain();

        set_config(1, 1, -32768, 32767, 32767, 32767);
        send_tick(1, 1, 0, 1, -32768);
        send_tick(1, 0, 0, 0, 0);
        send_tick(0, 1, 0, 1, 32767);
        send_tick(0, 1, 0, 1, 0);
        drain();

        // Swing ends given in the wrong order, with the motor stopped.
        set_config(0, 1, 5, -5, 0, 0);
        send_tick(1, 1, 0, 1, 9);
        send_tick(1, 1, 0, 1, 5);
        send_tick(1, 1, 0, 1, 0);
        send_tick(0, 0, 0, 0, 0);
        drain();

        set_idling(0);
        set_config(1, 0, 0, 0, 0, 0);
        run_fixed(150, 160);
        drain();

        set_idling(1);
        set_config(1, 1, -6, 6, 2, 3);
        run_swing(150, -8, 9);
        drain();

        set_idling(2);
        set_config(2, 0, 0, 0, 0, 0);
        run_fixed(140, 180);
        drain();

        set_idling(3);
        set_config(1, 1, 7, -7, 0, 1);
        run_swing(130, 7, -8);
        drain();

        set_idling(0);
        set_config(255, 0, 0, 0, 32767, 32767);
        run_fixed(70, 60);
        drain();

        set_idling(1);
        set_config(1, 1, -32760, 32760, 32767, 32767);
        run_swing(120, -32765, 32764);
        drain();

        set_idling(2);
        set_config($urandom_range(4, 1), 0, 0, 0, 0, 0);
        run_fixed(140, 150);
        drain();

        set_idling(3);
        set_config(0, 1, -3, 3, 1, 1);
        run_swing(60, -4, 4);
        drain();

        set_idling(0);
        set_config(1, 1, 0, 0, 0, 0);
        run_swing(120, 0, 0);
        drain();

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end
        else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
